/* hdl/modexp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation unit.
// No dependencies.
package modexp_pkg;

    localparam int WIDTH = 32;                 // operand and key width
    localparam int CNT_W = $clog2(WIDTH);      // bit position / step counter width
    localparam int IDX_W = 2;                  // configuration index width

    localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_REDUCE,
        ST_SAVE_BASE,
        ST_SQ_SETUP,
        ST_SQ_RUN,
        ST_SQ_SAVE,
        ST_MU_SETUP,
        ST_MU_RUN,
        ST_MU_SAVE,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_REDUCE,
        DP_STEP,
        DP_SAVE_BASE,
        DP_SQ_SETUP,
        DP_MU_SETUP,
        DP_SAVE_Y,
        DP_CONST_ZERO,
        DP_CONST_ONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_small;   // modulus below two
    } dp_stat_t;

endpackage

/* hdl/modexp_dp.sv */
`timescale 1ns / 1ps
// Datapath: shared shift-add modular multiplier, base and running power.
// Depends on modexp_pkg.
module modexp_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  modexp_pkg::dp_cmd_t           cmd,
    input  logic [modexp_pkg::WIDTH-1:0]  message,
    input  logic [modexp_pkg::WIDTH-1:0]  modulus,
    output modexp_pkg::dp_stat_t          stat,
    output logic [modexp_pkg::WIDTH-1:0]  result
);
    import modexp_pkg::*;

    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] acc_reg, acc_next;   // partial product, always below modulus
    logic [WIDTH-1:0] ma_reg,  ma_next;    // multiplicand
    logic [WIDTH-1:0] mb_reg,  mb_next;    // multiplier, scanned from the top bit
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] y_reg,   y_next;

    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] step_res;

    // one multiplier bit: acc = 2*acc mod m, then + ma mod m if bit set
    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= {1'b0, mod_reg}) ? WIDTH'(dbl - {1'b0, mod_reg}) : dbl[WIDTH-1:0];
        sum      = {1'b0, dbl_red} + (mb_reg[WIDTH-1] ? {1'b0, ma_reg} : '0);
        step_res = (sum >= {1'b0, mod_reg}) ? WIDTH'(sum - {1'b0, mod_reg}) : sum[WIDTH-1:0];
    end

    always_comb
    begin
        mod_next  = mod_reg;
        acc_next  = acc_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        base_next = base_reg;
        y_next    = y_reg;
        case (cmd.op)
            DP_LOAD_REDUCE:
            begin
                // message mod m taken as 1 * message mod m
                mod_next = modulus;
                ma_next  = WIDTH'(1);
                mb_next  = message;
                acc_next = '0;
            end
            DP_STEP:
            begin
                acc_next = step_res;
                mb_next  = {mb_reg[WIDTH-2:0], 1'b0};
            end
            DP_SAVE_BASE:
            begin
                base_next = acc_reg;
                y_next    = acc_reg;
            end
            DP_SQ_SETUP:
            begin
                ma_next  = y_reg;
                mb_next  = y_reg;
                acc_next = '0;
            end
            DP_MU_SETUP:
            begin
                ma_next  = base_reg;
                mb_next  = y_reg;
                acc_next = '0;
            end
            DP_SAVE_Y:     y_next = acc_reg;
            DP_CONST_ZERO: y_next = '0;
            DP_CONST_ONE:  y_next = WIDTH'(1);
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= '0;
            acc_reg  <= '0;
            ma_reg   <= '0;
            mb_reg   <= '0;
            base_reg <= '0;
            y_reg    <= '0;
        end
        else
        begin
            mod_reg  <= mod_next;
            acc_reg  <= acc_next;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            base_reg <= base_next;
            y_reg    <= y_next;
        end
    end

    assign stat.mod_small = (modulus[WIDTH-1:1] == '0);
    assign result         = y_reg;

endmodule

/* hdl/modexp_ctrl.sv */
`timescale 1ns / 1ps
// Controller: exponent scan and square-and-multiply sequencing.
// Depends on modexp_pkg.
module modexp_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [modexp_pkg::WIDTH-1:0]  exponent,
    input  modexp_pkg::dp_stat_t          stat,
    output modexp_pkg::dp_cmd_t           cmd,
    output logic                          busy,
    output logic                          done
);
    import modexp_pkg::*;

    state_t           state_reg, state_next;
    logic [WIDTH-1:0] e_reg,    e_next;      // exponent, current bit at the top
    logic [CNT_W-1:0] bits_reg, bits_next;   // exponent bits still below the top
    logic [CNT_W-1:0] step_reg, step_next;   // multiplier step
    logic             last_step;

    assign last_step = (step_reg == CNT_W'(WIDTH - 1));

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        bits_next  = bits_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    e_next    = exponent;
                    bits_next = CNT_W'(WIDTH - 1);
                    step_next = '0;
                    if (stat.mod_small || exponent == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (e_reg[WIDTH-1])
                    state_next = ST_REDUCE;
                else
                begin
                    e_next    = {e_reg[WIDTH-2:0], 1'b0};
                    bits_next = bits_reg - CNT_W'(1);
                end
            end
            ST_REDUCE, ST_SQ_RUN, ST_MU_RUN:
            begin
                step_next = step_reg + CNT_W'(1);
                if (last_step)
                begin
                    step_next = '0;
                    case (state_reg)
                        ST_REDUCE: state_next = ST_SAVE_BASE;
                        ST_SQ_RUN: state_next = ST_SQ_SAVE;
                        default:   state_next = ST_MU_SAVE;
                    endcase
                end
            end
            ST_SAVE_BASE, ST_MU_SAVE:
            begin
                state_next = (bits_reg == '0) ? ST_DONE : ST_SQ_SETUP;
            end
            ST_SQ_SETUP:
            begin
                e_next     = {e_reg[WIDTH-2:0], 1'b0};
                bits_next  = bits_reg - CNT_W'(1);
                state_next = ST_SQ_RUN;
            end
            ST_SQ_SAVE:
            begin
                if (e_reg[WIDTH-1])
                    state_next = ST_MU_SETUP;
                else if (bits_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_SQ_SETUP;
            end
            ST_MU_SETUP: state_next = ST_MU_RUN;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = DP_NOP;
        busy   = 1'b1;
        done   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (stat.mod_small)
                        cmd.op = DP_CONST_ZERO;
                    else if (exponent == '0)
                        cmd.op = DP_CONST_ONE;
                    else
                        cmd.op = DP_LOAD_REDUCE;
                end
            end
            ST_REDUCE, ST_SQ_RUN, ST_MU_RUN: cmd.op = DP_STEP;
            ST_SAVE_BASE:                    cmd.op = DP_SAVE_BASE;
            ST_SQ_SETUP:                     cmd.op = DP_SQ_SETUP;
            ST_MU_SETUP:                     cmd.op = DP_MU_SETUP;
            ST_SQ_SAVE, ST_MU_SAVE:          cmd.op = DP_SAVE_Y;
            ST_DONE:                         done   = 1'b1;
            default:                         cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            e_reg     <= '0;
            bits_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            bits_reg  <= bits_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* hdl/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps
// Top level of the modular exponentiation unit: key registers, controller, datapath.
// Depends on modexp_pkg, modexp_ctrl and modexp_dp.
//
//  channel   ports                       handshake
//  -------   -------------------------   ------------------------------------
//  input     start, busy, message        word taken when start & !busy
//  output    done, result                word valid for the single done cycle
//  config    wr_en, wr_index, wr_data    register written when wr_en is high
//
// Sequence per word: a modulus below two or a zero exponent goes straight to done.
// Otherwise a search for the top exponent bit, the base reduction, then a squaring
// pass per exponent bit below the top plus a multiply pass for each set one, then
// the done state; each pass runs the shared 32-step shift-add multiplier.
// Reset puts exponent at 1 and modulus at 2 and the controller in idle.
// The receiver cannot stall: result is valid only while done is high.
module modular_exponentiation_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [modexp_pkg::WIDTH-1:0]  message,
    output logic                          done,
    output logic [modexp_pkg::WIDTH-1:0]  result,
    input  logic                          wr_en,
    input  logic [modexp_pkg::IDX_W-1:0]  wr_index,
    input  logic [modexp_pkg::WIDTH-1:0]  wr_data
);
    import modexp_pkg::*;

    logic [WIDTH-1:0] exponent_reg, exponent_next;
    logic [WIDTH-1:0] modulus_reg,  modulus_next;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // key registers; writes to unknown indexes fall through
    always_comb
    begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_EXPONENT: exponent_next = wr_data;
                REG_MODULUS:  modulus_next  = wr_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= WIDTH'(1);
            modulus_reg  <= WIDTH'(2);
        end
        else
        begin
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
        end
    end

    // sequencing: top-bit search, then reduce, square and multiply passes
    modexp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .exponent (exponent_reg),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // one shared modular multiplier; result holds the running power
    modexp_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .message (message),
        .modulus (modulus_reg),
        .stat    (stat),
        .result  (result)
    );

    // a taken word makes the unit busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // done is raised only while a word is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a busy period");

    // done is a single-cycle strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // busy drops only right after the result word
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result word");

endmodule

/* test/modular_exponentiation_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the modular exponentiation unit: directed table, then random key phases.
// Depends on modexp_pkg and modular_exponentiation_unit.
module modular_exponentiation_unit_tb;

    import modexp_pkg::*;

    // Index values the unit has no register behind; writes there must change nothing.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);

    localparam int RAND_PHASES     = 9;
    localparam int WORDS_PER_PHASE = 30;

    typedef enum logic { ROW_WRITE, ROW_WORD } row_kind_t;

    // One line of the directed table. For a word row, idx is unused and data is the message;
    // typed marks a row whose result is written in by hand rather than predicted.
    typedef struct {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [WIDTH-1:0]  data;
        bit                typed;
        logic [WIDTH-1:0]  want;
    } stim_row_t;

    typedef struct {
        logic [WIDTH-1:0]  msg;
        logic [WIDTH-1:0]  power;
    } pending_pow_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic [WIDTH-1:0]  message  = '0;
    logic              wr_en    = 1'b0;
    logic [IDX_W-1:0]  wr_index = '0;
    logic [WIDTH-1:0]  wr_data  = '0;
    logic              busy;
    logic              done;
    logic [WIDTH-1:0]  result;

    // Shadow of the key registers, kept in step with every write we issue.
    logic [WIDTH-1:0]  key_exp = WIDTH'(1);
    logic [WIDTH-1:0]  key_mod = WIDTH'(2);

    pending_pow_t      pending_pows[$];
    int                err_count = 0;
    bit                no_gaps   = 1'b0;

    modular_exponentiation_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .message  (message),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // Left-to-right square-and-multiply over double-width products, so every
    // intermediate reduction is exact.
    function automatic logic [WIDTH-1:0] mod_power(input logic [WIDTH-1:0] msg,
                                                   input logic [WIDTH-1:0] ex,
                                                   input logic [WIDTH-1:0] md);
        logic [2*WIDTH-1:0] base;
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] md_w;
        int                 top;
        if (md < 2)
            return '0;
        if (ex == 0)
            return WIDTH'(1);
        md_w = {{WIDTH{1'b0}}, md};
        base = {{WIDTH{1'b0}}, msg} % md_w;
        acc  = base;
        top  = WIDTH - 1;
        while (top > 0 && !ex[top])
            top--;
        for (int i = top - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % md_w;
            if (ex[i])
                acc = (acc * base) % md_w;
        end
        return acc[WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string note, input logic [WIDTH-1:0] msg,
                                   input logic [WIDTH-1:0] got, input logic [WIDTH-1:0] want);
        $display("%0t ns: MISMATCH %s: message %h result %h expected %h",
                 $time, note, msg, got, want);
        err_count++;
    endtask

    // Results come for one cycle only and cannot be held off: sample every edge.
    always @(posedge clk)
    begin
        pending_pow_t exp_word;
        if (rst_n && done)
        begin
            if (pending_pows.size() == 0)
                report_mismatch("unexpected word", '0, result, '0);
            else
            begin
                exp_word = pending_pows.pop_front();
                if (result !== exp_word.power)
                    report_mismatch("result", exp_word.msg, result, exp_word.power);
            end
        end
    end

    // Offer one word; returns on the edge that takes it, with start still high so the
    // next word can follow without a dip.
    task automatic send_word(input logic [WIDTH-1:0] msg, input bit typed,
                             input logic [WIDTH-1:0] want);
        pending_pow_t exp_word;
        start   <= 1'b1;
        message <= msg;
        do
            @(posedge clk);
        while (busy);
        exp_word.msg   = msg;
        exp_word.power = typed ? want : mod_power(msg, key_exp, key_mod);
        pending_pows.push_back(exp_word);
    endtask

    // About 7 words in 100 are followed by a spell with start low.
    task automatic idle_after;
        int gap;
        if (!no_gaps && $urandom_range(0, 99) < 7)
        begin
            gap   = $urandom_range(1, 30);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Key writes only once the unit is idle and nothing is outstanding.
    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_pows.size() != 0 || busy);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WIDTH-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        case (idx)
            REG_EXPONENT: key_exp = val;
            REG_MODULUS:  key_mod = val;
            default: ;    // no register here
        endcase
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        stim_row_t         rows[$];
        bit                was_word;
        logic [WIDTH-1:0]  new_exp;
        logic [WIDTH-1:0]  new_mod;
        logic [WIDTH-1:0]  msg;

        // After reset: exponent 1, modulus 2, so each word gives its low bit.
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0000_0000, 1'b1, 32'h0000_0000});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0000_0002, 1'b1, 32'h0000_0000});
        // zero exponent always gives one
        rows.push_back('{ROW_WRITE, REG_EXPONENT, 32'h0000_0000, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0001_2345, 1'b1, 32'h0000_0001});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001});
        // widest key; a message equal to the modulus reduces to zero
        rows.push_back('{ROW_WRITE, REG_MODULUS,  32'hFFFF_FFFF, 1'b0, 32'h0});
        rows.push_back('{ROW_WRITE, REG_EXPONENT, 32'hFFFF_FFFF, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0000_0000, 1'b1, 32'h0000_0000});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0000_0001, 1'b1, 32'h0000_0001});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFE, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hDEAD_BEEF, 1'b0, 32'h0});
        // modulus of one, then of zero: result is zero
        rows.push_back('{ROW_WRITE, REG_MODULUS,  32'h0000_0001, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0000_ABCD, 1'b1, 32'h0000_0000});
        rows.push_back('{ROW_WRITE, REG_MODULUS,  32'h0000_0000, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h0000_0000, 1'b1, 32'h0000_0000});
        // usual public key against the largest 32-bit prime
        rows.push_back('{ROW_WRITE, REG_MODULUS,  32'hFFFF_FFFB, 1'b0, 32'h0});
        rows.push_back('{ROW_WRITE, REG_EXPONENT, 32'h0001_0001, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h1234_5678, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h8000_0000, 1'b0, 32'h0});
        // writes to the spare indexes must leave the key alone
        rows.push_back('{ROW_WRITE, REG_SPARE_LO, 32'h0000_0000, 1'b0, 32'h0});
        rows.push_back('{ROW_WRITE, REG_SPARE_HI, 32'hFFFF_FFFF, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h1234_5678, 1'b0, 32'h0});
        // exponent one: plain reduction, 0xFFFFFFFF mod 0xFFFFFFFB = 4
        rows.push_back('{ROW_WRITE, REG_EXPONENT, 32'h0000_0001, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0004});
        // lone top bit in the exponent, tiny modulus
        rows.push_back('{ROW_WRITE, REG_EXPONENT, 32'h8000_0000, 1'b0, 32'h0});
        rows.push_back('{ROW_WRITE, REG_MODULUS,  32'h0000_0003, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'h7FFF_FFFF, 1'b0, 32'h0});
        // power-of-two modulus
        rows.push_back('{ROW_WRITE, REG_EXPONENT, 32'h0000_0003, 1'b0, 32'h0});
        rows.push_back('{ROW_WRITE, REG_MODULUS,  32'h8000_0000, 1'b0, 32'h0});
        rows.push_back('{ROW_WORD,  REG_EXPONENT, 32'hFFFF_FFFF, 1'b0, 32'h0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        was_word = 1'b0;
        foreach (rows[r])
        begin
            if (rows[r].kind == ROW_WRITE)
            begin
                if (was_word)
                    drain();
                write_reg(rows[r].idx, rows[r].data);
                was_word = 1'b0;
            end
            else
            begin
                send_word(rows[r].data, rows[r].typed, rows[r].want);
                idle_after();
                was_word = 1'b1;
            end
        end

        // Random key phases. Exponent and modulus shapes rotate so the extremes and the
        // trivial keys come round; two phases run with no gaps at all.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            case (p % 6)
                0:       new_exp = 32'h0001_0001;
                1:       new_exp = $urandom;
                2:       new_exp = $urandom_range(2, 255);
                3:       new_exp = 32'hFFFF_FFFF;
                4:       new_exp = (p == 4) ? 32'h0000_0000 : 32'h0000_0003;
                default: new_exp = $urandom;
            endcase
            case (p % 3)
                0:       new_mod = $urandom | 32'h8000_0001;
                1:       new_mod = $urandom_range(2, 65535);
                default: new_mod = $urandom;
            endcase
            write_reg(REG_EXPONENT, new_exp);
            write_reg(REG_MODULUS, new_mod);
            no_gaps = (p == 3 || p == 5);

            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                case ($urandom_range(0, 19))
                    0:       msg = '0;
                    1:       msg = '1;
                    2:       msg = key_mod - 1'b1;
                    3:       msg = key_mod;
                    4:       msg = WIDTH'($urandom_range(0, 15));
                    default: msg = $urandom;
                endcase
                send_word(msg, 1'b0, '0);
                idle_after();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The slowest correct run ends well before this timeout.
    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
